>>> hw/rtl/sfr_pkg.sv
// shared types and constants for the serial frame receiver with xor header check
// used by sfr_store and serial_frame_receiver_xor_check_unit
package sfr_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_TYPE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LENH  = 3'd3,
    PH_LENL  = 3'd4,
    PH_CHECK = 3'd5,
    PH_DATA  = 3'd6,
    PH_TAIL  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_HDR_OK = 3'd1,
    EV_RESYNC = 3'd2,
    EV_TEXT   = 3'd3,
    EV_CLOSED = 3'd4
  } event_t;

  // write request from the parser into the payload store
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

endpackage

>>> hw/rtl/serial_frame_receiver_xor_check_unit.sv
// top level of the serial frame receiver with xor header check
// depends on sfr_pkg and sfr_store
//
// Each word on the input channel is a received byte, a receiver restart, a
// payload read or an idle word, and gives exactly one result word. A word is
// accepted in every cycle unless the input is stalled, and its result passes
// through the input register (where the payload store read completes) and the
// parser update into the output register. The rate is set by the parser step
// and the one store port. Backpressure on the output stalls the input only
// when both registers are full. The store needs no clearing pass after reset:
// entries at or beyond the fill count of the current frame read as zero.
module serial_frame_receiver_xor_check_unit
  import sfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_rx_byte,
  input  logic [7:0]           in_read_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_data,
  output logic                 out_text_ready,
  output logic [15:0]          out_text_length,
  output logic [2:0]           out_frame_event,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // configuration
  logic [7:0] tail_byte_r, text_type_r;

  // input register
  logic       s1_valid_r;
  logic [1:0] s1_action_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_index_r;

  // parser state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [15:0]      decl_len_r, decl_len_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ready_flag_r, ready_flag_nxt;
  logic [15:0]      acc_len_r, acc_len_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_rd_r;
  logic        out_ready_flag_r;
  logic [15:0] out_len_r;
  event_t      out_ev_r;

  logic        advance, fire, in_fire;
  event_t      ev_nxt;
  logic [7:0]  rd_nxt;
  logic [7:0]  store_rd;
  wr_req_t     wr;
  logic [15:0] in_idx_w, s1_idx_w;
  logic [CNT_W-1:0] count_inc;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign in_idx_w = {8'd0, in_read_index};
  assign s1_idx_w = {8'd0, s1_index_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_byte_r <= 8'd0;
      text_type_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TAIL_BYTE: tail_byte_r <= cfg_data;
        REG_TEXT_TYPE: text_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_rx_byte;
      s1_index_r  <= in_read_index;
    end
  end

  sfr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_fire),
    .rd_addr (in_idx_w[BUF_AW-1:0]),
    .rd_data (store_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD1;
      kind_r       <= 8'd0;
      decl_len_r   <= 16'd0;
      xor_r        <= 8'd0;
      count_r      <= '0;
      ready_flag_r <= 1'b0;
      acc_len_r    <= 16'd0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      kind_r       <= kind_nxt;
      decl_len_r   <= decl_len_nxt;
      xor_r        <= xor_nxt;
      count_r      <= count_nxt;
      ready_flag_r <= ready_flag_nxt;
      acc_len_r    <= acc_len_nxt;
    end
  end

  assign count_inc = (count_r == {CNT_W{1'b1}}) ? count_r : count_r + CNT_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    decl_len_nxt   = decl_len_r;
    xor_nxt        = xor_r;
    count_nxt      = count_r;
    ready_flag_nxt = ready_flag_r;
    acc_len_nxt    = acc_len_r;
    ev_nxt         = EV_NONE;
    rd_nxt         = 8'd0;
    wr.en          = 1'b0;
    wr.addr        = count_r[BUF_AW-1:0];
    wr.data        = s1_byte_r;
    case (action_t'(s1_action_r))
      ACT_BYTE: begin
        case (phase_r)
          PH_HEAD1: begin
            if (s1_byte_r == HDR_FIRST) begin
              xor_nxt   = s1_byte_r;
              phase_nxt = PH_HEAD2;
            end
          end
          PH_HEAD2: begin
            if (s1_byte_r == HDR_SECOND) begin
              xor_nxt   = xor_r ^ s1_byte_r;
              phase_nxt = PH_TYPE;
            end else begin
              phase_nxt = PH_HEAD1;
            end
          end
          PH_TYPE: begin
            kind_nxt  = s1_byte_r;
            xor_nxt   = xor_r ^ s1_byte_r;
            phase_nxt = PH_LENH;
          end
          PH_LENH: begin
            decl_len_nxt = {s1_byte_r, 8'd0};
            xor_nxt      = xor_r ^ s1_byte_r;
            phase_nxt    = PH_LENL;
          end
          PH_LENL: begin
            decl_len_nxt = {decl_len_r[15:8], s1_byte_r};
            xor_nxt      = xor_r ^ s1_byte_r;
            phase_nxt    = PH_CHECK;
          end
          PH_CHECK: begin
            if (s1_byte_r == xor_r) begin
              // store is emptied by zeroing the fill count
              count_nxt = '0;
              phase_nxt = PH_DATA;
              ev_nxt    = EV_HDR_OK;
            end else begin
              phase_nxt = PH_HEAD1;
              ev_nxt    = EV_RESYNC;
            end
          end
          PH_DATA: begin
            wr.en     = fire && (count_r < CNT_W'(BUF_DEPTH));
            count_nxt = count_inc;
            if (count_inc >= decl_len_r) begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_TAIL: begin
            if ((s1_byte_r == tail_byte_r) && (kind_r == text_type_r)) begin
              acc_len_nxt    = decl_len_r;
              ready_flag_nxt = 1'b1;
              ev_nxt         = EV_TEXT;
            end else begin
              ev_nxt = EV_CLOSED;
            end
            phase_nxt = PH_HEAD1;
          end
          default: phase_nxt = PH_HEAD1;
        endcase
      end
      ACT_RESTART: begin
        ready_flag_nxt = 1'b0;
        acc_len_nxt    = 16'd0;
        phase_nxt      = PH_HEAD1;
      end
      ACT_READ: begin
        // entries past the fill count were not written in this frame
        if ((s1_idx_w < CNT_W'(BUF_DEPTH)) && (s1_idx_w < count_r)) begin
          rd_nxt = store_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rd_r         <= rd_nxt;
      out_ready_flag_r <= ready_flag_nxt;
      out_len_r        <= acc_len_nxt;
      out_ev_r         <= ev_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_rd_r;
  assign out_text_ready  = out_ready_flag_r;
  assign out_text_length = out_len_r;
  assign out_frame_event = out_ev_r;

`ifndef SYNTH
  a_text_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (ev_nxt == EV_TEXT)) |=> (out_text_ready && ready_flag_r))
    else $error("text frame accepted without ready flag");

  a_hdr_ok_starts_data: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (ev_nxt == EV_HDR_OK)) |=> ((count_r == '0) && (phase_r == PH_DATA)))
    else $error("header check pass did not start an empty payload");

  a_not_ready_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_flag_r |-> (acc_len_r == 16'd0))
    else $error("accepted length held while not ready");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> hw/rtl/sfr_store.sv
// payload store: one write port, one registered read port with write bypass
// depends on sfr_pkg
module sfr_store
  import sfr_pkg::*;
(
  input  logic              clk,
  input  wr_req_t           wr,
  input  logic              rd_en,
  input  logic [BUF_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // a write landing on the same edge as the read is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for serial_frame_receiver_xor_check_unit
// needs sfr_pkg and the rtl below it; predicts every result word in place

module testbench
  import sfr_pkg::*;
();

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    action_t    act;
    logic [7:0] rx;
    logic [7:0] idx;
  } word_t;

  typedef struct {
    logic [7:0]  read_data;
    logic        text_ready;
    logic [15:0] text_length;
    event_t      ev;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_action = 2'd0;
  logic [7:0]           in_rx_byte = 8'h00;
  logic [7:0]           in_read_index = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_read_data;
  logic                 out_text_ready;
  logic [15:0]          out_text_length;
  logic [2:0]           out_frame_event;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;

  serial_frame_receiver_xor_check_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_rx_byte      (in_rx_byte),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_text_ready  (out_text_ready),
    .out_text_length (out_text_length),
    .out_frame_event (out_frame_event),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // parser model state
  logic [7:0]  cfg_tail = 8'h00;
  logic [7:0]  cfg_text_type = 8'h00;
  phase_t      phase = PH_HEAD1;
  logic [7:0]  kind = 8'h00;
  logic [15:0] frame_len = 16'h0000;
  logic [7:0]  hdr_xor = 8'h00;
  logic [15:0] fill = 16'h0000;
  logic [7:0]  frame_store [BUF_DEPTH];
  logic        text_flag = 1'b0;
  logic [15:0] text_len = 16'h0000;

  word_t   pending_words [$];
  result_t due_results [$];

  int   snd_idle_pct = 27;
  int   rcv_idle_pct = 88;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  logic in_took = 1'b0;
  int   idle_cycles = 0;
  int   n_queued = 0;
  int   n_checked = 0;
  int   mismatch_cnt = 0;
  int   ev_seen [8];

  function automatic event_t take_rx(input logic [7:0] b);
    event_t ev;
    ev = EV_NONE;
    case (phase)
      PH_HEAD1: begin
        if (b == HDR_FIRST) begin
          hdr_xor = b;
          phase = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        // a wrong second byte is dropped, not retried as a first header byte
        if (b == HDR_SECOND) begin
          hdr_xor ^= b;
          phase = PH_TYPE;
        end else begin
          phase = PH_HEAD1;
        end
      end
      PH_TYPE: begin
        kind = b;
        hdr_xor ^= b;
        phase = PH_LENH;
      end
      PH_LENH: begin
        frame_len = {b, 8'h00};
        hdr_xor ^= b;
        phase = PH_LENL;
      end
      PH_LENL: begin
        frame_len = frame_len | {8'h00, b};
        hdr_xor ^= b;
        phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == hdr_xor) begin
          fill = 16'h0000;
          for (int i = 0; i < BUF_DEPTH; i++) frame_store[i] = 8'h00;
          phase = PH_DATA;
          ev = EV_HDR_OK;
        end else begin
          phase = PH_HEAD1;
          ev = EV_RESYNC;
        end
      end
      PH_DATA: begin
        // past the store size bytes are counted only; a zero length still takes one
        if (fill < BUF_DEPTH) frame_store[fill[BUF_AW-1:0]] = b;
        if (fill != 16'hFFFF) fill = fill + 16'd1;
        if (fill >= frame_len) phase = PH_TAIL;
      end
      default: begin
        if (b == cfg_tail && kind == cfg_text_type) begin
          text_len = frame_len;
          text_flag = 1'b1;
          ev = EV_TEXT;
        end else begin
          ev = EV_CLOSED;
        end
        phase = PH_HEAD1;
      end
    endcase
    return ev;
  endfunction

  function automatic result_t parse_word(input word_t w);
    result_t r;
    r.read_data = 8'h00;
    r.ev = EV_NONE;
    case (w.act)
      ACT_BYTE: r.ev = take_rx(w.rx);
      ACT_RESTART: begin
        // store, type, length and count survive a restart
        text_flag = 1'b0;
        text_len = 16'h0000;
        phase = PH_HEAD1;
      end
      ACT_READ: begin
        if (w.idx < BUF_DEPTH) r.read_data = frame_store[w.idx];
      end
      default: ;
    endcase
    r.text_ready = text_flag;
    r.text_length = text_len;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", n_checked, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic push_word(input action_t act, input logic [7:0] rx, input logic [7:0] idx);
    word_t w;
    w.act = act;
    w.rx = rx;
    w.idx = idx;
    pending_words.push_back(w);
    if (act != ACT_NONE) n_queued++;
  endtask

  task automatic push_rx(input logic [7:0] b);
    push_word(ACT_BYTE, b, 8'($urandom));
  endtask

  task automatic push_read(input logic [7:0] idx);
    push_word(ACT_READ, 8'($urandom), idx);
  endtask

  task automatic push_restart();
    push_word(ACT_RESTART, 8'($urandom), 8'($urandom));
  endtask

  // cut >= 0 aborts the payload with a restart after that many bytes
  task automatic push_frame(input logic [7:0] fkind, input logic [15:0] len,
                            input bit check_ok, input logic [7:0] tail, input int cut);
    logic [7:0] x;
    int         n;
    x = HDR_FIRST ^ HDR_SECOND ^ fkind ^ len[15:8] ^ len[7:0];
    push_rx(HDR_FIRST);
    push_rx(HDR_SECOND);
    push_rx(fkind);
    push_rx(len[15:8]);
    push_rx(len[7:0]);
    push_rx(check_ok ? x : x ^ 8'($urandom_range(1, 255)));
    if (!check_ok) return;
    n = (len == 16'h0000) ? 1 : int'(len);
    for (int i = 0; i < n; i++) begin
      if (i == cut) begin
        push_restart();
        return;
      end
      if ($urandom_range(15) == 0) push_read(8'($urandom));
      push_rx(8'($urandom));
    end
    push_rx(tail);
  endtask

  task automatic gen_traffic(input int target);
    int         stop;
    int         r;
    int         len;
    logic [7:0] fkind;
    logic [7:0] tail;
    logic [7:0] b;
    stop = n_queued + target;
    while (n_queued < stop) begin
      r = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      fkind = ($urandom_range(3) != 0) ? cfg_text_type : 8'($urandom);
      tail = ($urandom_range(4) != 0) ? cfg_tail : 8'($urandom);
      if (r < 60) begin
        push_frame(fkind, 16'(len), $urandom_range(9) != 0, tail, -1);
        repeat ($urandom_range(3)) push_read(8'($urandom_range(len + 1)));
      end else if (r < 68) begin
        // any declared length, usually cut short by a restart
        push_frame(fkind, 16'($urandom), 1'b1, tail, $urandom_range(20));
      end else if (r < 74) begin
        b = 8'($urandom);
        if (b == HDR_SECOND) b = HDR_FIRST;
        push_rx(HDR_FIRST);
        push_rx(b);
      end else if (r < 82) begin
        repeat ($urandom_range(1, 4)) push_rx(8'($urandom));
      end else if (r < 88) begin
        push_restart();
      end else if (r < 96) begin
        push_read(8'($urandom));
      end else begin
        push_word(ACT_NONE, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TAIL_BYTE) cfg_tail = val;
    else if (idx == REG_TEXT_TYPE) cfg_text_type = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds back until every word is through and every result is back
  task automatic settle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_in
    word_t w;
    if (!in_valid || in_took) begin
      if (rst_n && pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_action <= w.act;
        in_rx_byte <= w.rx;
        in_read_index <= w.idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_out_ready
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    word_t   w;
    result_t want;
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      w.act = action_t'(in_action);
      w.rx = in_rx_byte;
      w.idx = in_read_index;
      due_results.push_back(parse_word(w));
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("word with nothing expected, frame_event", 16'(out_frame_event), 16'h0);
      end else begin
        want = due_results.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", 16'(out_read_data), 16'(want.read_data));
        if (out_text_ready !== want.text_ready)
          report_mismatch("text_ready", 16'(out_text_ready), 16'(want.text_ready));
        if (out_text_length !== want.text_length)
          report_mismatch("text_length", out_text_length, want.text_length);
        if (out_frame_event !== want.ev)
          report_mismatch("frame_event", 16'(out_frame_event), 16'(want.ev));
        ev_seen[want.ev]++;
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, giving up", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : main
    for (int i = 0; i < BUF_DEPTH; i++) frame_store[i] = 8'h00;
    for (int i = 0; i < 8; i++) ev_seen[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset register values
    push_word(ACT_NONE, 8'hFF, 8'hFF);
    push_read(8'hFF);
    push_rx(HDR_FIRST);
    push_rx(HDR_FIRST);
    push_rx(HDR_SECOND);
    push_frame(8'h00, 16'h0000, 1'b1, 8'h00, -1);
    push_read(8'h00);
    push_read(8'h01);
    push_restart();
    push_frame(8'hFF, 16'hFFFF, 1'b0, 8'h00, -1);
    settle();

    write_reg(REG_TAIL_BYTE, 8'hFF);
    write_reg(REG_TEXT_TYPE, 8'h00);
    @(posedge clk);
    hold_req++;
    gen_traffic(470);
    settle();

    write_reg(REG_TAIL_BYTE, 8'($urandom));
    write_reg(REG_TEXT_TYPE, 8'($urandom));
    @(posedge clk);
    snd_idle_pct = 88;
    rcv_idle_pct = 27;
    gen_traffic(470);
    settle();

    write_reg(REG_TEXT_TYPE, 8'hFF);
    write_reg(REG_TAIL_BYTE, 8'h00);
    @(posedge clk);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req++;
    // one frame longer than the store, then reads across it
    push_frame(cfg_text_type, 16'd300, 1'b1, cfg_tail, -1);
    repeat (6) push_read(8'($urandom));
    gen_traffic(180);
    settle();
    repeat (8) @(posedge clk);

    if (due_results.size() != 0)
      report_mismatch("results never arrived", 16'(due_results.size()), 16'h0);
    $display("covered %0d words over four register settings: %0d text frames accepted,",
             n_checked, ev_seen[EV_TEXT]);
    $display("%0d closed unaccepted, %0d header checks passed, %0d resyncs",
             ev_seen[EV_CLOSED], ev_seen[EV_HDR_OK], ev_seen[EV_RESYNC]);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_store.sv
hw/rtl/serial_frame_receiver_xor_check_unit.sv
tb/testbench.sv
